// ----- sv/pdga_pkg.sv -----
// Shared constants, codes and controller/datapath interface types.
`timescale 1ns / 1ps
package pdga_pkg;

  localparam int GRID_DIM = 64;
  localparam int IDX_W    = $clog2(GRID_DIM);
  localparam int CELLS    = GRID_DIM * GRID_DIM;
  localparam int DIM_W    = IDX_W + 1;
  localparam int COORD_W  = 16;

  localparam logic [1:0] ST_ACCEPT = 2'd0;
  localparam logic [1:0] ST_BOUNDS = 2'd1;
  localparam logic [1:0] ST_CLOSE  = 2'd2;
  localparam logic [1:0] ST_CLEAR  = 2'd3;

  localparam logic [1:0] REG_RADIUS    = 2'd0;
  localparam logic [1:0] REG_CELL_SIZE = 2'd1;
  localparam logic [1:0] REG_GRID_W    = 2'd2;
  localparam logic [1:0] REG_GRID_H    = 2'd3;

  typedef struct packed {
    logic       capture;
    logic       clr_init;
    logic       clr_step;
    logic       div_start;
    logic       scan_init;
    logic       scan_step;
    logic       acc_rd;
    logic       acc_wr;
    logic       load_out;
    logic [1:0] out_code;
  } cmd_t;

  typedef struct packed {
    logic is_clear;
    logic clr_last;
    logic oob;
    logic div_done;
    logic scan_last;
    logic pipe_busy;
    logic hit;
  } sts_t;

endpackage

// ----- sv/poisson_disk_grid_acceptor.sv -----
// Top level of the Poisson-disk grid acceptor.
//
//   channel  direction  handshake            word
//   cfg      in         cfg_we               cfg_addr, cfg_data
//   in       in         in_valid/in_ready    op, cand_x, cand_y
//   out      out        out_valid/out_ready  status, cell_col, cell_row
//
// One word at a time. Clear: one valid row of 64 cells per cycle. Test: a bit-serial
// cell divide, then one neighbor read per cycle over the clipped window (up to 25 cells).
// After reset a clearing pass over all 64 rows runs before the first word is taken.
// A result waits in the output register; the next word enters once it is loaded.
`timescale 1ns / 1ps
module poisson_disk_grid_acceptor (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_addr,
  input  logic [15:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                op,
  input  logic signed [16:0]  cand_x,
  input  logic signed [16:0]  cand_y,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          status,
  output logic [5:0]          cell_col,
  output logic [5:0]          cell_row
);

  pdga_pkg::cmd_t cmd;
  pdga_pkg::sts_t sts;

  pdga_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .op        (op),
    .sts       (sts),
    .cmd       (cmd)
  );

  pdga_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .op       (op),
    .cand_x   (cand_x),
    .cand_y   (cand_y),
    .cmd      (cmd),
    .sts      (sts),
    .status   (status),
    .cell_col (cell_col),
    .cell_row (cell_row)
  );

`ifndef ASSERT_OFF
  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !sts.pipe_busy)
    else $error("distance pipe busy while idle");

  a_insert_no_hit: assert property (@(posedge clk) disable iff (rst)
    cmd.acc_wr |-> !sts.hit)
    else $error("insert after a close neighbor");

  a_load_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result overwrote an untaken word");

  a_capture_ready: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> in_ready && in_valid)
    else $error("capture outside a handshake");
`endif

endmodule

// ----- sv/pdga_div.sv -----
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module pdga_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [pdga_pkg::COORD_W-1:0] dividend,
  input  logic [pdga_pkg::COORD_W-1:0] divisor,
  output logic                         done,
  output logic [pdga_pkg::COORD_W-1:0] quo
);

  localparam int W = pdga_pkg::COORD_W;

  logic         busy;
  logic [4:0]   cnt;
  logic [W-1:0] rem;
  logic [W:0]   shifted;
  logic [W:0]   trial;

  assign shifted = {rem, quo[W-1]};
  assign trial   = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= 5'(W);
    end else if (busy) begin
      cnt <= cnt - 5'd1;
      if (cnt == 5'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      if (!trial[W]) begin
        rem <= trial[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= shifted[W-1:0];
        quo <= {quo[W-2:0], 1'b0};
      end
    end
  end

endmodule

// ----- sv/pdga_datapath.sv -----
// Datapath: config registers, dividers, grid memories, neighbor distance pipe.
`timescale 1ns / 1ps
module pdga_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_addr,
  input  logic [15:0]           cfg_data,
  input  logic                  op,
  input  logic signed [16:0]    cand_x,
  input  logic signed [16:0]    cand_y,
  input  pdga_pkg::cmd_t        cmd,
  output pdga_pkg::sts_t        sts,
  output logic [1:0]            status,
  output logic [5:0]            cell_col,
  output logic [5:0]            cell_row
);

  localparam int IW = pdga_pkg::IDX_W;
  localparam int DW = pdga_pkg::DIM_W;
  localparam int CW = pdga_pkg::COORD_W;
  localparam int GRID_BITS = pdga_pkg::GRID_DIM;

  logic [15:0]   radius;
  logic [15:0]   cell_size;
  logic [6:0]    grid_width;
  logic [6:0]    grid_height;

  logic [DW-1:0] gw;
  logic [DW-1:0] gh;
  logic [DW+CW-1:0] lim_x;
  logic [DW+CW-1:0] lim_y;
  logic [31:0]   r2;

  logic          op_q;
  logic [16:0]   x_q;
  logic [16:0]   y_q;

  logic          div_x_done;
  logic          div_y_done;
  logic [CW-1:0] quo_x;
  logic [CW-1:0] quo_y;
  logic [IW-1:0] col;
  logic [IW-1:0] row;

  logic [IW-1:0] clr_row;
  logic [IW-1:0] scan_c;
  logic [IW-1:0] scan_r;
  logic [IW-1:0] c0, c1, r0, r1;
  logic [DW-1:0] colp2, rowp2, gw_m1, gh_m1;

  logic [31:0]          pmem [pdga_pkg::CELLS];
  logic [GRID_BITS-1:0] vmem [pdga_pkg::GRID_DIM];

  logic [31:0]          pt_q;
  logic [GRID_BITS-1:0] vrow_q;
  logic [IW-1:0]        rd_row;

  logic                 s1_v;
  logic [IW-1:0]        s1_c;
  logic                 s2_v;
  logic [32:0]          sqx;
  logic [32:0]          sqy;
  logic signed [16:0]   dx;
  logic signed [16:0]   dy;
  logic signed [33:0]   px;
  logic signed [33:0]   py;
  logic [33:0]          d2;
  logic                 hit;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      radius      <= 16'd256;
      cell_size   <= 16'd181;
      grid_width  <= 7'd64;
      grid_height <= 7'd64;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        pdga_pkg::REG_RADIUS:    radius      <= cfg_data;
        pdga_pkg::REG_CELL_SIZE: cell_size   <= cfg_data;
        pdga_pkg::REG_GRID_W:    grid_width  <= cfg_data[6:0];
        pdga_pkg::REG_GRID_H:    grid_height <= cfg_data[6:0];
      endcase
    end
  end

  always_comb begin
    priority if (grid_width == 7'd0) gw = DW'(1);
    else if (grid_width > 7'(pdga_pkg::GRID_DIM)) gw = DW'(pdga_pkg::GRID_DIM);
    else gw = DW'(grid_width);
    priority if (grid_height == 7'd0) gh = DW'(1);
    else if (grid_height > 7'(pdga_pkg::GRID_DIM)) gh = DW'(pdga_pkg::GRID_DIM);
    else gh = DW'(grid_height);
  end

  // domain limits and radius squared track the config registers
  always_ff @(posedge clk) begin
    lim_x <= gw * cell_size;
    lim_y <= gh * cell_size;
    r2    <= radius * radius;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q <= op;
      x_q  <= cand_x;
      y_q  <= cand_y;
    end
  end

  assign sts.is_clear = !op_q;
  assign sts.oob = x_q[16] || y_q[16] ||
                   ({{DW{1'b0}}, x_q[15:0]} >= lim_x) ||
                   ({{DW{1'b0}}, y_q[15:0]} >= lim_y);

  pdga_div u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (x_q[15:0]),
    .divisor  (cell_size),
    .done     (div_x_done),
    .quo      (quo_x)
  );

  pdga_div u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (y_q[15:0]),
    .divisor  (cell_size),
    .done     (div_y_done),
    .quo      (quo_y)
  );

  assign sts.div_done = div_x_done && div_y_done;
  assign col = quo_x[IW-1:0];
  assign row = quo_y[IW-1:0];

  // 5x5 window clipped to the grid
  always_comb begin
    colp2 = {1'b0, col} + DW'(2);
    rowp2 = {1'b0, row} + DW'(2);
    gw_m1 = gw - DW'(1);
    gh_m1 = gh - DW'(1);
    c0 = (col >= IW'(2)) ? col - IW'(2) : '0;
    r0 = (row >= IW'(2)) ? row - IW'(2) : '0;
    c1 = (colp2 < gw_m1) ? colp2[IW-1:0] : gw_m1[IW-1:0];
    r1 = (rowp2 < gh_m1) ? rowp2[IW-1:0] : gh_m1[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_row <= '0;
      scan_c  <= '0;
      scan_r  <= '0;
    end else begin
      if (cmd.clr_init) clr_row <= '0;
      else if (cmd.clr_step) clr_row <= clr_row + IW'(1);
      if (cmd.scan_init) begin
        scan_c <= c0;
        scan_r <= r0;
      end else if (cmd.scan_step) begin
        if (scan_r == r1) begin
          scan_r <= r0;
          scan_c <= scan_c + IW'(1);
        end else begin
          scan_r <= scan_r + IW'(1);
        end
      end
    end
  end

  assign sts.clr_last  = (clr_row == IW'(pdga_pkg::GRID_DIM - 1));
  assign sts.scan_last = (scan_c == c1) && (scan_r == r1);

  // grid memories
  assign rd_row = cmd.acc_rd ? row : scan_r;

  always_ff @(posedge clk) begin
    pt_q   <= pmem[{scan_r, scan_c}];
    vrow_q <= vmem[rd_row];
    if (cmd.acc_wr) pmem[{row, col}] <= {y_q[15:0], x_q[15:0]};
    if (cmd.clr_step) vmem[clr_row] <= '0;
    else if (cmd.acc_wr) vmem[row] <= vrow_q | (GRID_BITS'(1) << col);
  end

  // distance pipe: read, square, compare
  always_comb begin
    dx = $signed({1'b0, x_q[15:0]}) - $signed({1'b0, pt_q[15:0]});
    dy = $signed({1'b0, y_q[15:0]}) - $signed({1'b0, pt_q[31:16]});
    px = dx * dx;
    py = dy * dy;
    d2 = {1'b0, sqx} + {1'b0, sqy};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      hit  <= 1'b0;
    end else begin
      s1_v <= cmd.scan_step;
      s2_v <= s1_v && vrow_q[s1_c];
      if (cmd.scan_init) hit <= 1'b0;
      else if (s2_v && (d2 < {2'b00, r2})) hit <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    s1_c <= scan_c;
    sqx  <= px[32:0];
    sqy  <= py[32:0];
  end

  assign sts.pipe_busy = s1_v || s2_v;
  assign sts.hit       = hit;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status <= cmd.out_code;
      if (cmd.out_code == pdga_pkg::ST_ACCEPT || cmd.out_code == pdga_pkg::ST_CLOSE) begin
        cell_col <= col;
        cell_row <= row;
      end else begin
        cell_col <= '0;
        cell_row <= '0;
      end
    end
  end

endmodule

// ----- sv/pdga_ctrl.sv -----
// Controller state machine: sequences clear, bounds, divide, scan and insert.
`timescale 1ns / 1ps
module pdga_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  logic           op,
  input  pdga_pkg::sts_t sts,
  output pdga_pkg::cmd_t cmd
);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CLR   = 4'd2;
  localparam logic [3:0] S_BOUND = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_SINIT = 4'd5;
  localparam logic [3:0] S_SCAN  = 4'd6;
  localparam logic [3:0] S_DRAIN = 4'd7;
  localparam logic [3:0] S_ACCRD = 4'd8;
  localparam logic [3:0] S_ACCWR = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [1:0] code;
  logic [1:0] code_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    code_next  = code;
    cmd        = '0;
    cmd.out_code = code;
    unique case (state)
      S_INIT: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (!op) begin
            cmd.clr_init = 1'b1;
            state_next   = S_CLR;
          end else begin
            state_next = S_BOUND;
          end
        end
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          code_next  = pdga_pkg::ST_CLEAR;
          state_next = S_DONE;
        end
      end
      S_BOUND: begin
        if (sts.oob) begin
          code_next  = pdga_pkg::ST_BOUNDS;
          state_next = S_DONE;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) state_next = S_SINIT;
      end
      S_SINIT: begin
        cmd.scan_init = 1'b1;
        state_next    = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (!sts.pipe_busy) begin
          if (sts.hit) begin
            code_next  = pdga_pkg::ST_CLOSE;
            state_next = S_DONE;
          end else begin
            state_next = S_ACCRD;
          end
        end
      end
      S_ACCRD: begin
        cmd.acc_rd = 1'b1;
        state_next = S_ACCWR;
      end
      S_ACCWR: begin
        cmd.acc_wr = 1'b1;
        code_next  = pdga_pkg::ST_ACCEPT;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      code      <= pdga_pkg::ST_ACCEPT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      code  <= code_next;
      if (cmd.load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule
